// ===== src/minute_event_scheduler_assert.svh =====
// Assertion macros for the minute event scheduler.
// Each expects i_clk and i_rst_n in the scope of the module that uses it.
`ifndef MINUTE_EVENT_SCHEDULER_ASSERT_SVH
`define MINUTE_EVENT_SCHEDULER_ASSERT_SVH
`ifndef SYNTHESIS
`define MES_ASSERT_SAME(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);
`define MES_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define MES_ASSERT_SAME(lbl, pre, post, msg)
`define MES_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== src/mes_pkg.sv =====
package mes_pkg;

    localparam int SLOTS       = 16;
    localparam int MAX_RESULTS = 16;
    localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SLOT_CW     = $clog2(SLOTS + 1);
    localparam int NCNT_W      = $clog2(MAX_RESULTS + 1);

    localparam int MIN_W  = 27;   // epoch minutes
    localparam int DAY_W  = 16;   // epoch days
    localparam int MOD_W  = 11;   // minute of day
    localparam int PER_W  = 14;   // interval period in minutes
    localparam int DIV_W  = MIN_W;
    localparam int PROD_W = 61;

    localparam int unsigned SECS_PER_MIN       = 60;
    localparam int unsigned MINS_PER_DAY       = 1440;
    localparam int unsigned MAX_INTERVAL_HOURS = 168;
    localparam logic [7:0]  DAYS_RESERVED_BIT  = 8'h80;

    // reciprocals: x/60 = (x>>2)/15, x/1440 = (x>>5)/45
    localparam logic [30:0] INV15 = 31'd1145324613;
    localparam logic [30:0] INV45 = 31'd5965233;
    localparam logic [30:0] INV7  = 31'd74899;

    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;

    localparam logic [1:0] RES_ACCEPT = 2'd0;
    localparam logic [1:0] RES_REJECT = 2'd1;
    localparam logic [1:0] RES_FIRED  = 2'd2;

    typedef enum logic [1:0] {
        EK_ONCE     = 2'd0,
        EK_INTERVAL = 2'd1,
        EK_DAILY    = 2'd2,
        EK_WEEKLY   = 2'd3
    } t_ekind;

    typedef struct packed {
        logic [63:0] id;
        logic [31:0] anchor;
        logic [7:0]  ivl;
        t_ekind      kind;
        logic [6:0]  days;
    } t_entry;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    typedef enum logic [4:0] {
        S_IDLE, S_DEC, S_T1, S_T2, S_T3, S_T4, S_T5,
        S_RD, S_A0, S_A1, S_A2, S_A3, S_A4, S_DIV, S_HIT, S_FLUSH,
        S_WCHK, S_WRD, S_WCMP, S_PUT
    } t_state;

endpackage

// ===== src/mes_div.sv =====
// Restoring remainder unit, one quotient bit per cycle.
module mes_div import mes_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [PER_W-1:0] i_divisor,
    output t_div_stat        o_stat,
    output logic [PER_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(DIV_W);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DIV_W-1:0] r_dvd, n_dvd;
    logic [PER_W-1:0] r_rem, n_rem;
    logic [PER_W-1:0] r_div, n_div;
    logic [PER_W:0]   trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        n_div  = r_div;
        trial  = {r_rem, r_dvd[DIV_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_dvd  = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_div}) begin
                trial = trial - {1'b0, r_div};
            end
            n_rem = trial[PER_W-1:0];
            n_dvd = {r_dvd[DIV_W-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DIV_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_rem       = r_rem;

endmodule

// ===== src/minute_event_scheduler.sv =====
// Minute event scheduler. A table of SLOTS schedules sits in one synchronous
// memory (registered read); valid bits and the last-seen minute are
// flip-flops. Requests are taken one at a time (o_stall is high while one is
// being worked). A tick splits the epoch into minute, minute of day and
// weekday (one shared 30x31 multiplier, reciprocal plus a correction step),
// then walks the slots, skipping empty ones; an interval slot gets its period
// remainder from a bit-serial divider. Fired IDs come out in slot order, at
// most MAX_RESULTS per tick; the final one has o_last set. A write scans
// the other valid slots for a duplicate ID. A result waits in the output
// register while the next request is accepted; the walk pauses only when a
// second result is due.
module minute_event_scheduler import mes_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic [3:0]  i_slot,
    input  logic [31:0] i_tick_epoch,
    input  logic        i_synced,
    input  logic [63:0] i_entry_id,
    input  logic [31:0] i_entry_anchor,
    input  logic [15:0] i_entry_interval,
    input  logic [7:0]  i_entry_kind,
    input  logic [7:0]  i_entry_days,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [63:0] o_fired_id,
    output logic        o_last
);

`include "minute_event_scheduler_assert.svh"

    // control
    t_state              r_state, n_state;
    logic [SLOTS-1:0]    r_valid, n_valid;
    logic [31:0]         r_last_min, n_last_min;
    logic [SLOT_CW-1:0]  r_idx, n_idx;
    logic [NCNT_W-1:0]   r_n, n_n;
    logic                r_pend_valid, n_pend_valid;
    logic                r_out_valid, n_out_valid;

    // payload
    logic [1:0]          r_mode, n_mode;
    logic [3:0]          r_slot, n_slot;
    logic [31:0]         r_now, n_now;
    logic                r_synced, n_synced;
    logic [63:0]         r_id, n_id;
    logic [31:0]         r_anchor, n_anchor;
    logic [15:0]         r_ivl, n_ivl;
    logic [7:0]          r_ekind, n_ekind;
    logic [7:0]          r_days, n_days;
    logic [MIN_W-1:0]    r_m, n_m;
    logic [MIN_W-1:0]    r_a, n_a;
    logic [MOD_W-1:0]    r_mod_now, n_mod_now;
    logic [DAY_W-1:0]    r_day, n_day;
    logic [2:0]          r_wday, n_wday;
    logic [PROD_W-1:0]   r_prod, n_prod;
    logic [63:0]         r_pend_id, n_pend_id;
    logic [1:0]          r_put_kind, n_put_kind;
    logic [1:0]          r_out_kind, n_out_kind;
    logic [63:0]         r_out_id, n_out_id;
    logic                r_out_last, n_out_last;

    // slot table
    t_entry              mem [SLOTS];
    t_entry              r_rd;
    logic                mem_we, rd_en;
    logic [IDX_W-1:0]    rd_addr, slot_idx;
    t_entry              wr_data;

    // shared multiplier operands
    logic [29:0]         mul_a;
    logic [30:0]         mul_b;

    // serial divider
    logic                div_start;
    logic [DIV_W-1:0]    div_dvd;
    logic [PER_W-1:0]    div_per;
    t_div_stat           div_stat;
    logic [PER_W-1:0]    div_rem;

    logic                can_put, entry_ok, in_acc;
    logic [MIN_W-1:0]    q60;
    logic [32:0]         rem60;
    logic [DAY_W-1:0]    qday;
    logic [27:0]         remday;
    logic [12:0]         q7;
    logic [16:0]         x7, rem7;
    logic [31:0]         src60;
    logic [MIN_W-1:0]    srcday;

    assign in_acc   = i_valid && !o_stall;
    assign can_put  = !r_out_valid || !i_stall;
    assign slot_idx = IDX_W'(r_slot);
    assign rd_addr  = r_idx[IDX_W-1:0];

    always_comb begin
        entry_ok = (r_id != 64'd0) && (r_anchor != 32'd0) && (r_ekind <= 8'(EK_WEEKLY));
        if (r_ekind == 8'(EK_INTERVAL)) begin
            entry_ok = entry_ok && (r_ivl >= 16'd1) && (32'(r_ivl) <= MAX_INTERVAL_HOURS);
        end else if (r_ekind == 8'(EK_WEEKLY)) begin
            entry_ok = entry_ok && (r_days != 8'd0) && ((r_days & DAYS_RESERVED_BIT) == 8'd0);
        end
        entry_ok = entry_ok && (32'(r_slot) < 32'(SLOTS));
    end

    // reciprocal quotient fix-ups, one per divisor (60, 1440, 7), shared by the stages that read r_prod
    always_comb begin
        src60  = (r_state == S_T1) ? r_now : r_rd.anchor;
        q60    = r_prod[34 +: MIN_W];
        rem60  = 33'(src60) - 33'(q60) * 33'(SECS_PER_MIN);
        if (rem60 >= 33'(SECS_PER_MIN)) begin
            q60 = q60 + 1'b1;
        end
        srcday = (r_state == S_T3) ? r_m : r_a;
        qday   = r_prod[28 +: DAY_W];
        remday = 28'(srcday) - 28'(qday) * 28'(MINS_PER_DAY);
        if (remday >= 28'(MINS_PER_DAY)) begin
            qday   = qday + 1'b1;
            remday = remday - 28'(MINS_PER_DAY);
        end
        x7   = 17'(r_day) + 17'd4;
        q7   = r_prod[19 +: 13];
        rem7 = x7 - 17'(q7) * 17'd7;
        if (rem7 >= 17'd7) begin
            rem7 = rem7 - 17'd7;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_valid      = r_valid;
        n_last_min   = r_last_min;
        n_idx        = r_idx;
        n_n          = r_n;
        n_pend_valid = r_pend_valid;
        n_mode       = r_mode;
        n_slot       = r_slot;
        n_now        = r_now;
        n_synced     = r_synced;
        n_id         = r_id;
        n_anchor     = r_anchor;
        n_ivl        = r_ivl;
        n_ekind      = r_ekind;
        n_days       = r_days;
        n_m          = r_m;
        n_a          = r_a;
        n_mod_now    = r_mod_now;
        n_day        = r_day;
        n_wday       = r_wday;
        n_pend_id    = r_pend_id;
        n_put_kind   = r_put_kind;
        n_out_valid  = r_out_valid && i_stall;
        n_out_kind   = r_out_kind;
        n_out_id     = r_out_id;
        n_out_last   = r_out_last;
        mul_a        = '0;
        mul_b        = '0;
        mem_we       = 1'b0;
        rd_en        = 1'b0;
        div_start    = 1'b0;
        div_dvd      = r_m - r_a;
        div_per      = PER_W'(r_rd.ivl * 14'(SECS_PER_MIN));
        wr_data.id     = r_id;
        wr_data.anchor = r_anchor;
        wr_data.ivl    = r_ivl[7:0];
        wr_data.kind   = t_ekind'(r_ekind[1:0]);
        wr_data.days   = r_days[6:0];

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_mode   = i_mode;
                    n_slot   = i_slot;
                    n_now    = i_tick_epoch;
                    n_synced = i_synced;
                    n_id     = i_entry_id;
                    n_anchor = i_entry_anchor;
                    n_ivl    = i_entry_interval;
                    n_ekind  = i_entry_kind;
                    n_days   = i_entry_days;
                    n_state  = S_DEC;
                end
            end
            S_DEC: begin
                unique case (r_mode)
                    MODE_TICK: begin
                        mul_a   = r_now[31:2];
                        mul_b   = INV15;
                        n_state = r_synced ? S_T1 : S_IDLE;
                    end
                    MODE_CLEAR: begin
                        n_valid    = '0;
                        n_last_min = '1;
                        n_put_kind = RES_ACCEPT;
                        n_state    = S_PUT;
                    end
                    MODE_WRITE: n_state = S_WCHK;
                    default:    n_state = S_IDLE;
                endcase
            end
            S_T1: begin
                // same minute as last tick: nothing to do
                if (32'(q60) == r_last_min) begin
                    n_state = S_IDLE;
                end else begin
                    n_last_min = 32'(q60);
                    n_m        = q60;
                    n_state    = S_T2;
                end
            end
            S_T2: begin
                mul_a   = 30'(r_m >> 5);
                mul_b   = INV45;
                n_state = S_T3;
            end
            S_T3: begin
                n_day     = qday;
                n_mod_now = remday[MOD_W-1:0];
                n_state   = S_T4;
            end
            S_T4: begin
                mul_a   = 30'(x7);
                mul_b   = INV7;
                n_state = S_T5;
            end
            S_T5: begin
                n_wday       = rem7[2:0];
                n_idx        = '0;
                n_n          = '0;
                n_pend_valid = 1'b0;
                n_state      = S_RD;
            end
            S_RD: begin
                if (r_idx == SLOT_CW'(SLOTS)) begin
                    n_state = S_FLUSH;
                end else if (!r_valid[rd_addr] || (r_n >= NCNT_W'(MAX_RESULTS))) begin
                    n_idx = r_idx + 1'b1;
                end else begin
                    rd_en   = 1'b1;
                    n_state = S_A0;
                end
            end
            S_A0: begin
                mul_a   = r_rd.anchor[31:2];
                mul_b   = INV15;
                n_state = S_A1;
            end
            S_A1: begin
                n_a     = q60;
                n_state = S_A2;
            end
            S_A2: begin
                n_idx   = r_idx + 1'b1;
                n_state = S_RD;
                unique case (r_rd.kind)
                    EK_ONCE: begin
                        if (r_m >= r_a) begin
                            n_idx   = r_idx;
                            n_state = S_HIT;
                        end
                    end
                    EK_INTERVAL: begin
                        if ((r_rd.ivl != 8'd0) && (r_m >= r_a)) begin
                            div_start = 1'b1;
                            n_idx     = r_idx;
                            n_state   = S_DIV;
                        end
                    end
                    default: begin
                        mul_a   = 30'(r_a >> 5);
                        mul_b   = INV45;
                        n_idx   = r_idx;
                        n_state = S_A3;
                    end
                endcase
            end
            S_A3: begin
                // daily or weekly: compare minute of day, weekly adds the mask
                if ((remday[MOD_W-1:0] == r_mod_now)
                    && ((r_rd.kind == EK_DAILY) || r_rd.days[r_wday])) begin
                    n_state = S_HIT;
                end else begin
                    n_state = S_A4;
                end
            end
            S_A4: begin
                n_idx   = r_idx + 1'b1;
                n_state = S_RD;
            end
            S_DIV: begin
                if (div_stat.done) begin
                    n_state = (div_rem == '0) ? S_HIT : S_A4;
                end
            end
            S_HIT: begin
                // hold one match back so the final one can carry o_last
                if (!r_pend_valid || can_put) begin
                    if (r_pend_valid) begin
                        n_out_valid = 1'b1;
                        n_out_kind  = RES_FIRED;
                        n_out_id    = r_pend_id;
                        n_out_last  = 1'b0;
                    end
                    n_pend_valid = 1'b1;
                    n_pend_id    = r_rd.id;
                    n_n          = r_n + 1'b1;
                    if (r_rd.kind == EK_ONCE) begin
                        n_valid[rd_addr] = 1'b0;
                    end
                    n_idx   = r_idx + 1'b1;
                    n_state = S_RD;
                end
            end
            S_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = S_IDLE;
                end else if (can_put) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = RES_FIRED;
                    n_out_id     = r_pend_id;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            S_WCHK: begin
                n_idx = '0;
                if (entry_ok) begin
                    n_state = S_WRD;
                end else begin
                    n_put_kind = RES_REJECT;
                    n_state    = S_PUT;
                end
            end
            S_WRD: begin
                if (r_idx == SLOT_CW'(SLOTS)) begin
                    mem_we            = 1'b1;
                    n_valid[slot_idx] = 1'b1;
                    n_last_min        = '1;
                    n_put_kind        = RES_ACCEPT;
                    n_state           = S_PUT;
                end else if ((r_idx == SLOT_CW'(r_slot)) || !r_valid[rd_addr]) begin
                    n_idx = r_idx + 1'b1;
                end else begin
                    rd_en   = 1'b1;
                    n_state = S_WCMP;
                end
            end
            S_WCMP: begin
                if (r_rd.id == r_id) begin
                    n_put_kind = RES_REJECT;
                    n_state    = S_PUT;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_WRD;
                end
            end
            S_PUT: begin
                if (can_put) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = r_put_kind;
                    n_out_id    = 64'd0;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        n_prod = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= '0;
            r_last_min   <= '1;
            r_idx        <= '0;
            r_n          <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_valid      <= n_valid;
            r_last_min   <= n_last_min;
            r_idx        <= n_idx;
            r_n          <= n_n;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_slot     <= n_slot;
        r_now      <= n_now;
        r_synced   <= n_synced;
        r_id       <= n_id;
        r_anchor   <= n_anchor;
        r_ivl      <= n_ivl;
        r_ekind    <= n_ekind;
        r_days     <= n_days;
        r_m        <= n_m;
        r_a        <= n_a;
        r_mod_now  <= n_mod_now;
        r_day      <= n_day;
        r_wday     <= n_wday;
        r_prod     <= n_prod;
        r_pend_id  <= n_pend_id;
        r_put_kind <= n_put_kind;
        r_out_kind <= n_out_kind;
        r_out_id   <= n_out_id;
        r_out_last <= n_out_last;
    end

    // slot table memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[slot_idx] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    mes_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_per),
        .o_stat     (div_stat),
        .o_rem      (div_rem)
    );

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_kind     = r_out_kind;
    assign o_fired_id = r_out_id;
    assign o_last     = r_out_last;

    `MES_ASSERT_SAME(a_idle_no_pend, r_state == S_IDLE, !r_pend_valid, "match left pending")
    `MES_ASSERT_NEXT(a_acc_busy, in_acc, r_state == S_DEC, "accepted request not decoded")
    `MES_ASSERT_SAME(a_div_owner, div_stat.busy, r_state == S_DIV, "divider busy outside wait")
    `MES_ASSERT_SAME(a_status_id, o_valid && (o_kind != RES_FIRED),
                     (o_fired_id == 64'd0) && o_last, "status result carries an ID")

endmodule
